@@ src/cdv_pkg.sv @@
package cdv_pkg;

	// Field widths of one request and one result
	localparam int FUNC_W  = 2;
	localparam int COORD_W = 7;
	localparam int VALUE_W = 16;
	localparam int PROD_W  = 2 * VALUE_W;
	localparam int SUM_W   = 48;

	// Request function codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD_KERNEL = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_IMAGE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE     = 2'd2;

	// Output geometry codes
	localparam logic [1:0] MODE_VALID = 2'd0;
	localparam logic [1:0] MODE_FULL  = 2'd1;
	localparam logic [1:0] MODE_SAME  = 2'd2;

	// Register file layout on the APB port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam logic [2:0] REG_CONV_MODE   = 3'd0;
	localparam logic [2:0] REG_IMAGE_ROWS  = 3'd1;
	localparam logic [2:0] REG_IMAGE_COLS  = 3'd2;
	localparam logic [2:0] REG_KERNEL_ROWS = 3'd3;
	localparam logic [2:0] REG_KERNEL_COLS = 3'd4;

	// Depth of the command and result queues
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic [COORD_W-1:0]        row;
		logic [COORD_W-1:0]        col;
		logic signed [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic                    status;
	} out_item_t;

	typedef struct packed {
		logic [1:0] conv_mode;
		logic [6:0] image_rows;
		logic [6:0] image_cols;
		logic [3:0] kernel_rows;
		logic [3:0] kernel_cols;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		conv_mode:   MODE_VALID,
		image_rows:  7'd64,
		image_cols:  7'd64,
		kernel_rows: 4'd3,
		kernel_cols: 4'd3
	};

	typedef enum logic [1:0] {
		CMD_LOAD_KERNEL,
		CMD_LOAD_IMAGE,
		CMD_COMPUTE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic [COORD_W-1:0]        row;
		logic [COORD_W-1:0]        col;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

endpackage

@@ src/cdv_queue.sv @@
module cdv_queue #(
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  T     din,
	input  logic pop,
	output logic empty,
	output T     dout
);
	import cdv_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	T               mem_q [QUEUE_DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  count_q;
	logic           wr;
	logic           rd;

	// Occupancy flags and the handshake qualifiers
	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign dout  = mem_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd) begin
				rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_q] <= din;
		end
	end

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !empty)
		else $error("queue empty right after an accepted push");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

@@ src/cdv_front.sv @@
module cdv_front #(
	parameter int MAX_IMAGE_ROWS  = 64,
	parameter int MAX_IMAGE_COLS  = 64,
	parameter int MAX_KERNEL_ROWS = 8,
	parameter int MAX_KERNEL_COLS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  cdv_pkg::in_item_t item,
	output logic              cmd_push,
	input  logic              cmd_full,
	output cdv_pkg::cmd_t     cmd
);
	import cdv_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t decoded;
	logic keep;
	logic take;

	// The stage holds while its request waits on a full command queue
	assign full     = valid_s1 && cmd_full;
	assign take     = push && !full;
	assign cmd_push = valid_s1;
	assign cmd      = cmd_s1;

	// Classify the request; loads outside the stores and unused codes are dropped
	always_comb begin
		decoded.row   = item.row;
		decoded.col   = item.col;
		decoded.value = item.value;
		case (item.func)
			FUNC_LOAD_KERNEL: begin
				decoded.kind = CMD_LOAD_KERNEL;
				keep = (32'(item.row) < 32'(MAX_KERNEL_ROWS))
					&& (32'(item.col) < 32'(MAX_KERNEL_COLS));
			end
			FUNC_LOAD_IMAGE: begin
				decoded.kind = CMD_LOAD_IMAGE;
				keep = (32'(item.row) < 32'(MAX_IMAGE_ROWS))
					&& (32'(item.col) < 32'(MAX_IMAGE_COLS));
			end
			FUNC_COMPUTE: begin
				decoded.kind = CMD_COMPUTE;
				keep = 1'b1;
			end
			default: begin
				decoded.kind = CMD_COMPUTE;
				keep = 1'b0;
			end
		endcase
	end

	// Stage valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= take && keep;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= decoded;
		end
	end

endmodule

@@ src/cdv_back.sv @@
module cdv_back #(
	parameter int MAX_IMAGE_ROWS  = 64,
	parameter int MAX_IMAGE_COLS  = 64,
	parameter int MAX_KERNEL_ROWS = 8,
	parameter int MAX_KERNEL_COLS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cdv_pkg::cfg_t      cfg,
	input  logic               cmd_empty,
	input  cdv_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output cdv_pkg::out_item_t res
);
	import cdv_pkg::*;

	localparam int IMG_DEPTH = MAX_IMAGE_ROWS * MAX_IMAGE_COLS;
	localparam int KRN_DEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
	localparam int IAW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int KAW = (KRN_DEPTH > 1) ? $clog2(KRN_DEPTH) : 1;
	localparam int IRI = (MAX_IMAGE_ROWS > 1) ? $clog2(MAX_IMAGE_ROWS) : 1;
	localparam int ICI = (MAX_IMAGE_COLS > 1) ? $clog2(MAX_IMAGE_COLS) : 1;
	localparam int KRI = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
	localparam int KCI = (MAX_KERNEL_COLS > 1) ? $clog2(MAX_KERNEL_COLS) : 1;
	localparam int IRC = $clog2(MAX_IMAGE_ROWS + 1);
	localparam int ICC = $clog2(MAX_IMAGE_COLS + 1);
	localparam int KRC = $clog2(MAX_KERNEL_ROWS + 1);
	localparam int KCC = $clog2(MAX_KERNEL_COLS + 1);
	localparam int SW  = $clog2((2 ** COORD_W) + MAX_IMAGE_ROWS + MAX_IMAGE_COLS
		+ MAX_KERNEL_ROWS + MAX_KERNEL_COLS) + 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic [KRI-1:0]            m_q;
	logic [KCI-1:0]            n_q;
	logic [COORD_W-1:0]        orow_q;
	logic [COORD_W-1:0]        ocol_q;
	logic signed [SUM_W-1:0]   acc_q;
	logic                      res_status_q;

	logic [IRC-1:0]            ir;
	logic [ICC-1:0]            ic;
	logic [KRC-1:0]            kr;
	logic [KCC-1:0]            kc;
	logic [KRI-1:0]            kr_last;
	logic [KCI-1:0]            kc_last;
	logic signed [SW-1:0]      pr;
	logic signed [SW-1:0]      pc;
	logic signed [SW-1:0]      out_rows;
	logic signed [SW-1:0]      out_cols;
	logic                      mode_ok;
	logic                      outside;

	logic                      issue;
	logic                      last_tap;
	logic signed [SW-1:0]      r_pos;
	logic signed [SW-1:0]      c_pos;
	logic                      r_in;
	logic                      c_in;
	logic [KRI-1:0]            kr_idx;
	logic [KCI-1:0]            kc_idx;
	logic [IAW-1:0]            img_ra;
	logic [KAW-1:0]            krn_ra;
	logic [IAW-1:0]            img_wa;
	logic [KAW-1:0]            krn_wa;
	logic                      img_we;
	logic                      krn_we;

	logic signed [VALUE_W-1:0] img_mem [IMG_DEPTH];
	logic signed [VALUE_W-1:0] krn_mem [KRN_DEPTH];
	logic signed [VALUE_W-1:0] img_rd_s1;
	logic signed [VALUE_W-1:0] krn_rd_s1;
	logic                      vld_s1;
	logic                      tap_s1;
	logic                      last_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic                      vld_s2;
	logic                      last_s2;

	// Sizes in use: zero counts as one, and each saturates at its store limit
	always_comb begin
		if (cfg.image_rows == '0) begin
			ir = IRC'(1);
		end else if (32'(cfg.image_rows) > 32'(MAX_IMAGE_ROWS)) begin
			ir = IRC'(MAX_IMAGE_ROWS);
		end else begin
			ir = IRC'(cfg.image_rows);
		end
		if (cfg.image_cols == '0) begin
			ic = ICC'(1);
		end else if (32'(cfg.image_cols) > 32'(MAX_IMAGE_COLS)) begin
			ic = ICC'(MAX_IMAGE_COLS);
		end else begin
			ic = ICC'(cfg.image_cols);
		end
		if (cfg.kernel_rows == '0) begin
			kr = KRC'(1);
		end else if (32'(cfg.kernel_rows) > 32'(MAX_KERNEL_ROWS)) begin
			kr = KRC'(MAX_KERNEL_ROWS);
		end else begin
			kr = KRC'(cfg.kernel_rows);
		end
		if (cfg.kernel_cols == '0) begin
			kc = KCC'(1);
		end else if (32'(cfg.kernel_cols) > 32'(MAX_KERNEL_COLS)) begin
			kc = KCC'(MAX_KERNEL_COLS);
		end else begin
			kc = KCC'(cfg.kernel_cols);
		end
	end

	assign kr_last = KRI'(kr - KRC'(1));
	assign kc_last = KCI'(kc - KCC'(1));

	// Padding and output extent of the selected geometry
	always_comb begin
		mode_ok = 1'b1;
		case (cfg.conv_mode)
			MODE_VALID: begin
				pr       = '0;
				pc       = '0;
				out_rows = SW'(ir) - SW'(kr) + SW'(1);
				out_cols = SW'(ic) - SW'(kc) + SW'(1);
			end
			MODE_FULL: begin
				pr       = SW'(kr) - SW'(1);
				pc       = SW'(kc) - SW'(1);
				out_rows = SW'(ir) + SW'(kr) - SW'(1);
				out_cols = SW'(ic) + SW'(kc) - SW'(1);
			end
			MODE_SAME: begin
				pr       = SW'(kr >> 1);
				pc       = SW'(kc >> 1);
				out_rows = SW'(ir);
				out_cols = SW'(ic);
			end
			default: begin
				mode_ok  = 1'b0;
				pr       = '0;
				pc       = '0;
				out_rows = '0;
				out_cols = '0;
			end
		endcase
	end

	assign outside = !mode_ok
		|| ($signed(SW'(cmd.row)) >= out_rows)
		|| ($signed(SW'(cmd.col)) >= out_cols);

	// Command dispatch and store writes
	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty;
	assign img_we  = cmd_pop && (cmd.kind == CMD_LOAD_IMAGE);
	assign krn_we  = cmd_pop && (cmd.kind == CMD_LOAD_KERNEL);
	assign img_wa  = IAW'(IAW'(IRI'(cmd.row)) * IAW'(MAX_IMAGE_COLS)) + IAW'(ICI'(cmd.col));
	assign krn_wa  = KAW'(KAW'(KRI'(cmd.row)) * KAW'(MAX_KERNEL_COLS)) + KAW'(KCI'(cmd.col));

	// Tap address generation: image position and flipped kernel position
	assign issue    = (state_q == ST_RUN);
	assign last_tap = (m_q == kr_last) && (n_q == kc_last);
	assign r_pos    = SW'(orow_q) + SW'(m_q) - pr;
	assign c_pos    = SW'(ocol_q) + SW'(n_q) - pc;
	assign r_in     = !r_pos[SW-1] && (r_pos < $signed(SW'(ir)));
	assign c_in     = !c_pos[SW-1] && (c_pos < $signed(SW'(ic)));
	assign kr_idx   = KRI'(kr - KRC'(1) - KRC'(m_q));
	assign kc_idx   = KCI'(kc - KCC'(1) - KCC'(n_q));
	assign img_ra   = IAW'(IAW'($unsigned(IRI'(r_pos))) * IAW'(MAX_IMAGE_COLS))
		+ IAW'($unsigned(ICI'(c_pos)));
	assign krn_ra   = KAW'(KAW'(kr_idx) * KAW'(MAX_KERNEL_COLS)) + KAW'(kc_idx);

	// Image store
	always_ff @(posedge clk) begin
		if (img_we) begin
			img_mem[img_wa] <= cmd.value;
		end
		if (issue) begin
			img_rd_s1 <= img_mem[img_ra];
		end
	end

	// Kernel store
	always_ff @(posedge clk) begin
		if (krn_we) begin
			krn_mem[krn_wa] <= cmd.value;
		end
		if (issue) begin
			krn_rd_s1 <= krn_mem[krn_ra];
		end
	end

	// Pipeline control: read stage, then multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			tap_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= issue;
			tap_s1  <= issue && r_in && c_in;
			last_s1 <= issue && last_tap;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	// Product of one tap; padding taps contribute zero
	always_ff @(posedge clk) begin
		prod_s2 <= tap_s1 ? PROD_W'(img_rd_s1 * krn_rd_s1) : '0;
	end

	// Sequencer over the kernel window with the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			m_q          <= '0;
			n_q          <= '0;
			orow_q       <= '0;
			ocol_q       <= '0;
			acc_q        <= '0;
			res_status_q <= 1'b0;
		end else begin
			if (vld_s2) begin
				acc_q <= acc_q + {{(SUM_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && (cmd.kind == CMD_COMPUTE)) begin
						orow_q <= cmd.row;
						ocol_q <= cmd.col;
						m_q    <= '0;
						n_q    <= '0;
						acc_q  <= '0;
						if (outside) begin
							res_status_q <= 1'b1;
							state_q      <= ST_DONE;
						end else begin
							res_status_q <= 1'b0;
							state_q      <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (n_q == kc_last) begin
						n_q <= '0;
						if (m_q == kr_last) begin
							state_q <= ST_DRAIN;
						end else begin
							m_q <= m_q + 1'b1;
						end
					end else begin
						n_q <= n_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (last_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Finished result toward the result queue
	assign res_push   = (state_q == ST_DONE) && !res_full;
	assign res.sum    = acc_q;
	assign res.status = res_status_q;

	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		last_s2 |-> (state_q == ST_DRAIN))
		else $error("last tap reached the accumulator outside the drain state");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(vld_s1 || vld_s2))
		else $error("tap pipeline busy while the sequencer is idle");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && res_status_q) |-> (acc_q == '0))
		else $error("rejected position carries a nonzero sum");

endmodule

@@ src/conv2d_valid_full_same.sv @@
// Load requests are written into their store as the back end takes them; a compute
// request holds the back end while the single shared multiply-accumulate steps over
// its kernel window, and the back end takes no further command until the result is
// pushed. A position outside the output skips the window and returns status set.
// arst_n clears all control state and loads the register reset values; the
// image and kernel stores hold no defined contents until written.
module conv2d_valid_full_same #(
	parameter int MAX_IMAGE_ROWS  = 64,
	parameter int MAX_IMAGE_COLS  = 64,
	parameter int MAX_KERNEL_ROWS = 8,
	parameter int MAX_KERNEL_COLS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  cdv_pkg::in_item_t             item,
	output logic                          empty,
	input  logic                          pop,
	output cdv_pkg::out_item_t            result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdv_pkg::APB_AW-1:0]    paddr,
	input  logic [cdv_pkg::APB_DW-1:0]    pwdata,
	output logic [cdv_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import cdv_pkg::*;

	cfg_t      cfg_q;
	logic      cfg_we;
	logic      fq_push;
	logic      fq_full;
	cmd_t      fq_din;
	logic      cq_empty;
	logic      cq_pop;
	cmd_t      cq_dout;
	logic      rq_push;
	logic      rq_full;
	out_item_t rq_din;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (paddr[APB_AW-1:2])
				REG_CONV_MODE:   cfg_q.conv_mode   <= pwdata[1:0];
				REG_IMAGE_ROWS:  cfg_q.image_rows  <= pwdata[6:0];
				REG_IMAGE_COLS:  cfg_q.image_cols  <= pwdata[6:0];
				REG_KERNEL_ROWS: cfg_q.kernel_rows <= pwdata[3:0];
				REG_KERNEL_COLS: cfg_q.kernel_cols <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Register read back
	always_comb begin
		case (paddr[APB_AW-1:2])
			REG_CONV_MODE:   prdata = APB_DW'(cfg_q.conv_mode);
			REG_IMAGE_ROWS:  prdata = APB_DW'(cfg_q.image_rows);
			REG_IMAGE_COLS:  prdata = APB_DW'(cfg_q.image_cols);
			REG_KERNEL_ROWS: prdata = APB_DW'(cfg_q.kernel_rows);
			REG_KERNEL_COLS: prdata = APB_DW'(cfg_q.kernel_cols);
			default:         prdata = '0;
		endcase
	end

	// Front end: accepts and classifies requests
	cdv_front #(
		.MAX_IMAGE_ROWS  (MAX_IMAGE_ROWS),
		.MAX_IMAGE_COLS  (MAX_IMAGE_COLS),
		.MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
		.MAX_KERNEL_COLS (MAX_KERNEL_COLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_push (fq_push),
		.cmd_full (fq_full),
		.cmd      (fq_din)
	);

	// Command queue between front and back
	cdv_queue #(
		.T (cmd_t)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.full   (fq_full),
		.din    (fq_din),
		.pop    (cq_pop),
		.empty  (cq_empty),
		.dout   (cq_dout)
	);

	// Back end: stores and the multiply-accumulate sequencer
	cdv_back #(
		.MAX_IMAGE_ROWS  (MAX_IMAGE_ROWS),
		.MAX_IMAGE_COLS  (MAX_IMAGE_COLS),
		.MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
		.MAX_KERNEL_COLS (MAX_KERNEL_COLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cq_empty),
		.cmd       (cq_dout),
		.cmd_pop   (cq_pop),
		.res_full  (rq_full),
		.res_push  (rq_push),
		.res       (rq_din)
	);

	// Result queue toward the consumer
	cdv_queue #(
		.T (out_item_t)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.full   (rq_full),
		.din    (rq_din),
		.pop    (pop),
		.empty  (empty),
		.dout   (result)
	);

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import cdv_pkg::*;

	localparam int MAX_IR = 64;
	localparam int MAX_IC = 64;
	localparam int MAX_KR = 8;
	localparam int MAX_KC = 8;

	// Codes that the package leaves unnamed.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic [1:0]        MODE_UNUSED = 2'd3;

	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 80;
	localparam int MAX_REPORTS   = 40;
	localparam int IDLE_SWAP_AT  = 420;
	localparam int IDLE_OFF_AT   = 840;

	// Tracks the stores and registers of the block and the sums still owed by it.
	class conv_scoreboard;
		logic signed [VALUE_W-1:0] kernel_taps [MAX_KR*MAX_KC];
		logic signed [VALUE_W-1:0] image_px [MAX_IR*MAX_IC];
		bit kernel_set [MAX_KR*MAX_KC];
		bit image_set [MAX_IR*MAX_IC];
		cfg_t regs;
		out_item_t pending_sums[$];
		int errors;
		int ir_used, ic_used, kr_used, kc_used;
		int pad_rows, pad_cols, out_rows, out_cols;

		function new();
			regs = CFG_RESET;
			errors = 0;
			update_geometry();
		endfunction

		function int clamp_size(int v, int limit);
			if (v == 0) return 1;
			if (v > limit) return limit;
			return v;
		endfunction

		// Sizes in use, padding and output extent for the current mode.
		function void update_geometry();
			ir_used = clamp_size(regs.image_rows, MAX_IR);
			ic_used = clamp_size(regs.image_cols, MAX_IC);
			kr_used = clamp_size(regs.kernel_rows, MAX_KR);
			kc_used = clamp_size(regs.kernel_cols, MAX_KC);
			case (regs.conv_mode)
				MODE_VALID: begin
					pad_rows = 0;
					pad_cols = 0;
					out_rows = ir_used - kr_used + 1;
					out_cols = ic_used - kc_used + 1;
				end
				MODE_FULL: begin
					pad_rows = kr_used - 1;
					pad_cols = kc_used - 1;
					out_rows = ir_used + kr_used - 1;
					out_cols = ic_used + kc_used - 1;
				end
				MODE_SAME: begin
					pad_rows = kr_used / 2;
					pad_cols = kc_used / 2;
					out_rows = ir_used;
					out_cols = ic_used;
				end
				default: begin
					pad_rows = 0;
					pad_cols = 0;
					out_rows = 0;
					out_cols = 0;
				end
			endcase
		endfunction

		function void set_reg(logic [2:0] reg_index, logic [APB_DW-1:0] data);
			case (reg_index)
				REG_CONV_MODE:   regs.conv_mode = data[1:0];
				REG_IMAGE_ROWS:  regs.image_rows = data[6:0];
				REG_IMAGE_COLS:  regs.image_cols = data[6:0];
				REG_KERNEL_ROWS: regs.kernel_rows = data[3:0];
				REG_KERNEL_COLS: regs.kernel_cols = data[3:0];
				default: ;
			endcase
			update_geometry();
		endfunction

		function bit in_output(int orow, int ocol);
			return orow < out_rows && ocol < out_cols;
		endfunction

		// Pairs of image and kernel store entries that one output position multiplies.
		function void window_taps(int orow, int ocol, output int pixel_at[$],
				output int tap_at[$]);
			int r, c;
			pixel_at.delete();
			tap_at.delete();
			for (int m = 0; m < kr_used; m++) begin
				r = orow + m - pad_rows;
				if (r < 0 || r >= ir_used) continue;
				for (int n = 0; n < kc_used; n++) begin
					c = ocol + n - pad_cols;
					if (c < 0 || c >= ic_used) continue;
					pixel_at.push_back(r * MAX_IC + c);
					tap_at.push_back((kr_used - 1 - m) * MAX_KC + (kc_used - 1 - n));
				end
			end
		endfunction

		// Loads with random values for every entry a compute would read unwritten.
		function void missing_loads(int orow, int ocol, output in_item_t fills[$]);
			int pixel_at[$];
			int tap_at[$];
			in_item_t req;
			fills.delete();
			if (!in_output(orow, ocol)) return;
			window_taps(orow, ocol, pixel_at, tap_at);
			foreach (pixel_at[i]) begin
				if (!image_set[pixel_at[i]]) begin
					req.func = FUNC_LOAD_IMAGE;
					req.row = 7'(pixel_at[i] / MAX_IC);
					req.col = 7'(pixel_at[i] % MAX_IC);
					req.value = 16'($urandom);
					fills.push_back(req);
				end
			end
			foreach (tap_at[i]) begin
				if (!kernel_set[tap_at[i]]) begin
					req.func = FUNC_LOAD_KERNEL;
					req.row = 7'(tap_at[i] / MAX_KC);
					req.col = 7'(tap_at[i] % MAX_KC);
					req.value = 16'($urandom);
					fills.push_back(req);
				end
			end
		endfunction

		// Updates the stores for a load, or queues the sum a compute must return.
		function void apply_request(in_item_t req);
			int pixel_at[$];
			int tap_at[$];
			int slot;
			longint acc;
			out_item_t res;
			case (req.func)
				FUNC_LOAD_KERNEL: begin
					if (req.row < MAX_KR && req.col < MAX_KC) begin
						slot = req.row * MAX_KC + req.col;
						kernel_taps[slot] = req.value;
						kernel_set[slot] = 1'b1;
					end
				end
				FUNC_LOAD_IMAGE: begin
					if (req.row < MAX_IR && req.col < MAX_IC) begin
						slot = req.row * MAX_IC + req.col;
						image_px[slot] = req.value;
						image_set[slot] = 1'b1;
					end
				end
				FUNC_COMPUTE: begin
					res = '0;
					res.status = 1'b1;
					if (in_output(req.row, req.col)) begin
						window_taps(req.row, req.col, pixel_at, tap_at);
						acc = 0;
						foreach (pixel_at[i])
							acc += longint'(image_px[pixel_at[i]]) *
								longint'(kernel_taps[tap_at[i]]);
						res.sum = SUM_W'(acc);
						res.status = 1'b0;
					end
					pending_sums.push_back(res);
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= MAX_REPORTS) $display("mismatch: %s", what);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (pending_sums.size() == 0) begin
				report_mismatch($sformatf("result with no request pending: sum %0d status %0b",
					got.sum, got.status));
				return;
			end
			want = pending_sums.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0b, wanted %0b", got.status, want.status));
			if (got.sum !== want.sum)
				report_mismatch($sformatf("sum %0d, wanted %0d", got.sum, want.sum));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic push, full, empty, pop;
	in_item_t item;
	out_item_t result;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	conv_scoreboard sb;
	int requests_accepted = 0;
	int send_idle_pct = 29;
	int recv_idle_pct = 47;
	int stalled_cycles = 0;

	conv2d_valid_full_same u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	// The receiver stalls at random; each accepted result is checked at once.
	always @(negedge clk) begin
		pop <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) sb.check_result(result);
	end

	// The run ends as failed when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || psel)
				stalled_cycles = 0;
			else
				stalled_cycles++;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic in_item_t make_request(logic [FUNC_W-1:0] func, int row, int col,
			int value);
		in_item_t req;
		req.func = func;
		req.row = 7'(row);
		req.col = 7'(col);
		req.value = 16'(value);
		return req;
	endfunction

	// Offers one request, with random idle cycles before it, until it is taken.
	task automatic send_request(in_item_t req);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= req;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.apply_request(req);
		requests_accepted++;
		if (requests_accepted >= IDLE_OFF_AT) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end else if (requests_accepted >= IDLE_SWAP_AT) begin
			send_idle_pct = 47;
			recv_idle_pct = 29;
		end
	endtask

	// Waits until every result is back and the back end has finished any load.
	task automatic wait_until_idle();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending_sums.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes one register, then reads it back.
	task automatic write_reg(logic [2:0] reg_index, int value);
		logic [APB_DW-1:0] data;
		data = APB_DW'(value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_index, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(reg_index, data);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== data)
			sb.report_mismatch($sformatf("register %0d reads %0h, wrote %0h",
				reg_index, prdata, data));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_geometry(logic [1:0] mode, int irows, int icols, int krows, int kcols);
		wait_until_idle();
		write_reg(REG_CONV_MODE, mode);
		write_reg(REG_IMAGE_ROWS, irows);
		write_reg(REG_IMAGE_COLS, icols);
		write_reg(REG_KERNEL_ROWS, krows);
		write_reg(REG_KERNEL_COLS, kcols);
	endtask

	// Random traffic: mostly computes inside the output, each preceded by the loads
	// its window still lacks, mixed with stray loads, odd positions and unused codes.
	task automatic run_random(int budget);
		in_item_t req;
		in_item_t fills[$];
		int issued;
		int pick;
		bit ignored;
		issued = 0;
		while (issued < budget) begin
			pick = $urandom_range(0, 99);
			req.value = 16'($urandom);
			req.row = 7'($urandom);
			req.col = 7'($urandom);
			ignored = 1'b0;
			if (pick < 55) begin
				req.func = FUNC_COMPUTE;
				if (pick < 47 && sb.out_rows > 0 && sb.out_cols > 0) begin
					req.row = 7'($urandom_range(0, sb.out_rows - 1));
					req.col = 7'($urandom_range(0, sb.out_cols - 1));
				end
				sb.missing_loads(req.row, req.col, fills);
				foreach (fills[k]) send_request(fills[k]);
				issued += fills.size();
			end else if (pick < 78) begin
				req.func = FUNC_LOAD_IMAGE;
				if (pick < 74) begin
					req.row = 7'($urandom_range(0, sb.ir_used - 1));
					req.col = 7'($urandom_range(0, sb.ic_used - 1));
				end
				ignored = req.row >= MAX_IR || req.col >= MAX_IC;
			end else if (pick < 93) begin
				req.func = FUNC_LOAD_KERNEL;
				if (pick < 90) begin
					req.row = 7'($urandom_range(0, sb.kr_used - 1));
					req.col = 7'($urandom_range(0, sb.kc_used - 1));
				end
				ignored = req.row >= MAX_KR || req.col >= MAX_KC;
			end else begin
				req.func = FUNC_UNUSED;
				ignored = 1'b1;
			end
			send_request(req);
			if (!ignored) issued++;
		end
	endtask

	task automatic run_phase(logic [1:0] mode, int irows, int icols, int krows, int kcols,
			int budget);
		set_geometry(mode, irows, icols, krows, kcols);
		run_random(budget);
	endtask

	initial begin
		logic [1:0] mode;
		sb = new();
		push = 1'b0;
		item = '0;
		pop = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part on a 3 by 2 image and a 2 by 2 kernel in valid mode,
		// with the largest sample and coefficient magnitudes.
		set_geometry(MODE_VALID, 3, 2, 2, 2);
		send_request(make_request(FUNC_LOAD_KERNEL, 0, 0, -32768));
		send_request(make_request(FUNC_LOAD_KERNEL, 0, 1, 32767));
		send_request(make_request(FUNC_LOAD_KERNEL, 1, 0, -32768));
		send_request(make_request(FUNC_LOAD_KERNEL, 1, 1, 1));
		send_request(make_request(FUNC_LOAD_IMAGE, 0, 0, -32768));
		send_request(make_request(FUNC_LOAD_IMAGE, 0, 1, -32768));
		send_request(make_request(FUNC_LOAD_IMAGE, 1, 0, 32767));
		send_request(make_request(FUNC_LOAD_IMAGE, 1, 1, -32768));
		send_request(make_request(FUNC_LOAD_IMAGE, 2, 0, 0));
		send_request(make_request(FUNC_LOAD_IMAGE, 2, 1, 32767));
		send_request(make_request(FUNC_LOAD_IMAGE, 63, 63, -1));
		send_request(make_request(FUNC_COMPUTE, 0, 0, 0));
		send_request(make_request(FUNC_COMPUTE, 1, 0, -1));
		// Positions past the output answer with status set and a zero sum.
		send_request(make_request(FUNC_COMPUTE, 2, 0, 0));
		send_request(make_request(FUNC_COMPUTE, 0, 1, 0));
		send_request(make_request(FUNC_COMPUTE, 127, 127, 0));
		// Loads beyond the stores and the unused code must leave the stores alone.
		send_request(make_request(FUNC_LOAD_KERNEL, 8, 0, 12345));
		send_request(make_request(FUNC_LOAD_KERNEL, 0, 127, 12345));
		send_request(make_request(FUNC_LOAD_IMAGE, 64, 1, 12345));
		send_request(make_request(FUNC_LOAD_IMAGE, 127, 127, 12345));
		send_request(make_request(FUNC_UNUSED, 127, 127, -1));
		send_request(make_request(FUNC_COMPUTE, 1, 0, 0));
		send_request(make_request(FUNC_LOAD_KERNEL, 1, 1, -1));
		send_request(make_request(FUNC_COMPUTE, 0, 0, 0));

		// Fixed settings: the largest kernel, an even kernel height in same mode,
		// zero and saturating sizes, the unused mode and an empty valid output.
		run_phase(MODE_FULL, 5, 6, 8, 8, 100);
		run_phase(MODE_SAME, 7, 4, 4, 5, 100);
		run_phase(MODE_VALID, 0, 0, 0, 0, 40);
		run_phase(MODE_UNUSED, 9, 9, 3, 3, 30);
		run_phase(MODE_VALID, 2, 3, 5, 2, 30);
		run_phase(MODE_FULL, 127, 127, 15, 15, 150);
		run_phase(MODE_SAME, 64, 64, 1, 1, 60);
		run_phase(MODE_VALID, 64, 1, 8, 1, 50);

		// Random settings, mostly with small images.
		for (int p = 0; p < 8; p++) begin
			if ($urandom_range(0, 9) == 0)
				mode = MODE_UNUSED;
			else
				mode = 2'($urandom_range(0, 2));
			run_phase(mode, $urandom_range(1, 12), $urandom_range(1, 12),
				$urandom_range(1, 8), $urandom_range(1, 8), 80);
		end

		wait_until_idle();
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
